// ===== design/sdfa_pkg.sv =====
// ----------------------------------------------------------------------------
// sdfa_pkg
// shared types and codes of the stress divergence face accumulator
// ----------------------------------------------------------------------------
package sdfa_pkg;

   localparam int ID_W        = 6;
   localparam int IN_W        = 32;
   localparam int VAL_W       = 34;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [1:0] REQ_FACE       = 2'd0;
   localparam logic [1:0] REQ_RD_COLLOID = 2'd1;
   localparam logic [1:0] REQ_RD_WALL    = 2'd2;

   localparam logic [1:0] NB_FLUID   = 2'd0;
   localparam logic [1:0] NB_WALL    = 2'd1;
   localparam logic [1:0] NB_COLLOID = 2'd2;

   localparam logic [2:0] DIR_MAX = 3'd5;

   localparam logic [1:0] KIND_CELL    = 2'd0;
   localparam logic [1:0] KIND_COLLOID = 2'd1;
   localparam logic [1:0] KIND_WALL    = 2'd2;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CELL,
      OP_WALL,
      OP_COLLOID,
      OP_RD_COLLOID,
      OP_RD_WALL,
      OP_RD_ZERO
   } op_type;

   typedef logic signed [VAL_W-1:0] val_type;

   typedef struct packed {
      op_type          op;
      logic            last;
      logic [ID_W-1:0] id;
      val_type         v0;
      val_type         v1;
      val_type         v2;
   } item_type;

endpackage

// ===== design/sdfa_front.sv =====
// ----------------------------------------------------------------------------
// sdfa_front
// accepts request beats, classifies them and forms the signed face values
// ----------------------------------------------------------------------------
module sdfa_front #(
   parameter int MAX_COLLOIDS = 64
) (
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_type,
   input  logic [2:0]                         req_face_dir,
   input  logic [1:0]                         req_neighbour_kind,
   input  logic [sdfa_pkg::ID_W-1:0]          req_colloid_id,
   input  logic signed [sdfa_pkg::IN_W-1:0]   req_centre_c0,
   input  logic signed [sdfa_pkg::IN_W-1:0]   req_centre_c1,
   input  logic signed [sdfa_pkg::IN_W-1:0]   req_centre_c2,
   input  logic signed [sdfa_pkg::IN_W-1:0]   req_neigh_c0,
   input  logic signed [sdfa_pkg::IN_W-1:0]   req_neigh_c1,
   input  logic signed [sdfa_pkg::IN_W-1:0]   req_neigh_c2,
   input  logic                               req_last_face,
   input  logic                               q_full,
   output logic                               q_push,
   output sdfa_pkg::item_type                 q_item
);

   logic signed [sdfa_pkg::IN_W-1:0]  cen [3];
   logic signed [sdfa_pkg::IN_W-1:0]  nei [3];
   logic signed [sdfa_pkg::IN_W:0]    sum [3];
   logic signed [sdfa_pkg::VAL_W-1:0] val [3];
   logic signed [sdfa_pkg::VAL_W-1:0] tc  [3];
   logic                              id_ok;
   logic                              face_ok;
   logic                              keep;

   assign cen[0] = req_centre_c0;
   assign cen[1] = req_centre_c1;
   assign cen[2] = req_centre_c2;
   assign nei[0] = req_neigh_c0;
   assign nei[1] = req_neigh_c1;
   assign nei[2] = req_neigh_c2;

   assign id_ok   = int'(req_colloid_id) < MAX_COLLOIDS;
   assign face_ok = (req_face_dir <= sdfa_pkg::DIR_MAX) &&
                    (req_neighbour_kind == sdfa_pkg::NB_FLUID ||
                     req_neighbour_kind == sdfa_pkg::NB_WALL ||
                     req_neighbour_kind == sdfa_pkg::NB_COLLOID);

   // midpoint floors for fluid neighbours, else the centre value; plus faces subtract from the cell
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum[i] = (sdfa_pkg::IN_W+1)'(cen[i]) + (sdfa_pkg::IN_W+1)'(nei[i]);
         if (req_neighbour_kind == sdfa_pkg::NB_FLUID) begin
            val[i] = sdfa_pkg::VAL_W'($signed(sum[i][sdfa_pkg::IN_W:1]));
         end else begin
            val[i] = sdfa_pkg::VAL_W'(cen[i]);
         end
         tc[i] = req_face_dir[0] ? val[i] : -val[i];
      end
   end

   always_comb begin
      keep        = 1'b1;
      q_item.op   = sdfa_pkg::OP_NONE;
      q_item.last = 1'b0;
      q_item.id   = req_colloid_id;
      q_item.v0   = tc[0];
      q_item.v1   = tc[1];
      q_item.v2   = tc[2];
      case (req_type)
         sdfa_pkg::REQ_FACE: begin
            q_item.last = req_last_face;
            if (face_ok) begin
               case (req_neighbour_kind)
                  sdfa_pkg::NB_WALL:    q_item.op = sdfa_pkg::OP_WALL;
                  sdfa_pkg::NB_COLLOID: q_item.op = id_ok ? sdfa_pkg::OP_COLLOID
                                                          : sdfa_pkg::OP_CELL;
                  default:              q_item.op = sdfa_pkg::OP_CELL;
               endcase
            end
         end
         sdfa_pkg::REQ_RD_COLLOID: begin
            q_item.op = id_ok ? sdfa_pkg::OP_RD_COLLOID : sdfa_pkg::OP_RD_ZERO;
         end
         sdfa_pkg::REQ_RD_WALL: begin
            q_item.op = sdfa_pkg::OP_RD_WALL;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready && keep;

endmodule

// ===== design/sdfa_queue.sv =====
// ----------------------------------------------------------------------------
// sdfa_queue
// short queue of classified items between the front and the back
// ----------------------------------------------------------------------------
module sdfa_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  sdfa_pkg::item_type wr_item,
   output logic               full,
   output logic               rd_valid,
   output sdfa_pkg::item_type rd_item,
   input  logic               rd_en
);

   sdfa_pkg::item_type                slot_ff [sdfa_pkg::QUEUE_DEPTH];
   logic [sdfa_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [sdfa_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [sdfa_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;

   assign full     = cnt_ff == sdfa_pkg::QCNT_W'(sdfa_pkg::QUEUE_DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// ===== design/sdfa_back.sv =====
// ----------------------------------------------------------------------------
// sdfa_back
// executes items: saturating accumulators, colloid store and result register
// ----------------------------------------------------------------------------
module sdfa_back #(
   parameter int MAX_COLLOIDS = 64,
   parameter int ACC_WIDTH    = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  sdfa_pkg::item_type          q_item,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_result_kind,
   output logic signed [ACC_WIDTH-1:0] rsp_vec_x,
   output logic signed [ACC_WIDTH-1:0] rsp_vec_y,
   output logic signed [ACC_WIDTH-1:0] rsp_vec_z
);

   localparam int AW          = ACC_WIDTH;
   localparam int ID_RANGE    = 2 ** sdfa_pkg::ID_W;
   localparam int STORE_DEPTH = (MAX_COLLOIDS < ID_RANGE) ? MAX_COLLOIDS : ID_RANGE;
   localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int SW          = ((AW > sdfa_pkg::VAL_W) ? AW : sdfa_pkg::VAL_W) + 1;
   localparam logic signed [SW-1:0] ACC_MAX = SW'({1'b0, {(AW-1){1'b1}}});
   localparam logic signed [SW-1:0] ACC_MIN = ~ACC_MAX;

   typedef logic signed [AW-1:0] acc_type;

   function automatic acc_type sat_add(input acc_type a, input sdfa_pkg::val_type b);
      logic signed [SW-1:0] s;
      s = SW'(a) + SW'(b);
      if (s > ACC_MAX) begin
         sat_add = AW'(ACC_MAX);
      end else if (s < ACC_MIN) begin
         sat_add = AW'(ACC_MIN);
      end else begin
         sat_add = AW'(s);
      end
   endfunction

   logic [3*AW-1:0]       mem [STORE_DEPTH];
   logic                  vld_ff [STORE_DEPTH];

   logic                  b_valid_ff;
   sdfa_pkg::item_type    b_item_ff;
   logic [3*AW-1:0]       rd_data_ff;
   logic                  rd_vld_ff;
   logic                  byp_ff;
   logic [3*AW-1:0]       byp_data_ff;

   acc_type               cell_ff [3];
   acc_type               wall_ff [3];
   acc_type               cell_in [3];
   acc_type               wall_in [3];
   acc_type               cur_row [3];
   acc_type               cell_sum [3];
   acc_type               wall_sum [3];
   acc_type               row_sum  [3];
   acc_type               out_vec  [3];
   sdfa_pkg::val_type     vv [3];
   logic [3*AW-1:0]       row_new;

   logic                  rsp_valid_ff;
   logic [1:0]            kind_ff;
   acc_type               vec_ff [3];
   logic [1:0]            kind_in;

   logic                  is_add;
   logic                  is_face;
   logic                  is_read;
   logic                  needs_out;
   logic                  out_free;
   logic                  b_done;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [IDX_W-1:0]      rd_addr;

   assign vv[0] = b_item_ff.v0;
   assign vv[1] = b_item_ff.v1;
   assign vv[2] = b_item_ff.v2;

   assign is_add  = b_item_ff.op == sdfa_pkg::OP_CELL ||
                    b_item_ff.op == sdfa_pkg::OP_WALL ||
                    b_item_ff.op == sdfa_pkg::OP_COLLOID;
   assign is_face = is_add || b_item_ff.op == sdfa_pkg::OP_NONE;
   assign is_read = b_item_ff.op == sdfa_pkg::OP_RD_COLLOID ||
                    b_item_ff.op == sdfa_pkg::OP_RD_WALL ||
                    b_item_ff.op == sdfa_pkg::OP_RD_ZERO;
   assign needs_out = is_face ? b_item_ff.last : is_read;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign b_done   = b_valid_ff && (!needs_out || out_free);
   assign q_pop    = q_valid && (!b_valid_ff || b_done);

   assign wr_en   = b_done && b_item_ff.op == sdfa_pkg::OP_COLLOID;
   assign wr_addr = b_item_ff.id[IDX_W-1:0];
   assign rd_addr = q_item.id[IDX_W-1:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (byp_ff) begin
            cur_row[i] = byp_data_ff[i*AW +: AW];
         end else if (rd_vld_ff) begin
            cur_row[i] = rd_data_ff[i*AW +: AW];
         end else begin
            cur_row[i] = '0;
         end
         cell_sum[i] = sat_add(cell_ff[i], vv[i]);
         wall_sum[i] = sat_add(wall_ff[i], -vv[i]);
         row_sum[i]  = sat_add(cur_row[i], -vv[i]);
         row_new[i*AW +: AW] = row_sum[i];
         cell_in[i] = cell_ff[i];
         wall_in[i] = wall_ff[i];
         if (b_done && is_add) begin
            cell_in[i] = cell_sum[i];
         end
         if (b_done && b_item_ff.op == sdfa_pkg::OP_WALL) begin
            wall_in[i] = wall_sum[i];
         end
         if (b_done && is_face && b_item_ff.last) begin
            cell_in[i] = '0;
         end
      end
   end

   always_comb begin
      kind_in = sdfa_pkg::KIND_CELL;
      for (int i = 0; i < 3; i++) begin
         out_vec[i] = is_add ? cell_sum[i] : cell_ff[i];
      end
      case (b_item_ff.op)
         sdfa_pkg::OP_RD_COLLOID: begin
            kind_in = sdfa_pkg::KIND_COLLOID;
            for (int i = 0; i < 3; i++) out_vec[i] = cur_row[i];
         end
         sdfa_pkg::OP_RD_ZERO: begin
            kind_in = sdfa_pkg::KIND_COLLOID;
            for (int i = 0; i < 3; i++) out_vec[i] = '0;
         end
         sdfa_pkg::OP_RD_WALL: begin
            kind_in = sdfa_pkg::KIND_WALL;
            for (int i = 0; i < 3; i++) out_vec[i] = wall_ff[i];
         end
         default: begin
            kind_in = sdfa_pkg::KIND_CELL;
         end
      endcase
   end

   // control and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            cell_ff[i] <= '0;
            wall_ff[i] <= '0;
         end
         for (int k = 0; k < STORE_DEPTH; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         if (q_pop) begin
            b_valid_ff <= 1'b1;
         end else if (b_done) begin
            b_valid_ff <= 1'b0;
         end
         if (b_done && needs_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         for (int i = 0; i < 3; i++) begin
            cell_ff[i] <= cell_in[i];
            wall_ff[i] <= wall_in[i];
         end
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // back stage payload, store read and write-to-read bypass
   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_item_ff   <= q_item;
         rd_data_ff  <= mem[rd_addr];
         rd_vld_ff   <= vld_ff[rd_addr];
         byp_ff      <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= row_new;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= row_new;
      end
   end

   always_ff @(posedge clock) begin
      if (b_done && needs_out) begin
         kind_ff <= kind_in;
         for (int i = 0; i < 3; i++) begin
            vec_ff[i] <= out_vec[i];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_vec_x       = vec_ff[0];
   assign rsp_vec_y       = vec_ff[1];
   assign rsp_vec_z       = vec_ff[2];

endmodule

// ===== design/stress_divergence_face_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// stress_divergence_face_accumulator_top
// per-face stress divergence accumulation into cell, wall and colloid forces
//
//   channel   direction   handshake             payload
//   req_      in          req_valid/req_ready   type, face, neighbour, stress columns
//   rsp_      out         rsp_valid/rsp_ready   result kind, force vector
//
// one beat per cycle sustained while the result register is not stalled; a
// beat that needs a result passes the queue and the back stage into the result register
// the colloid store is read when an item leaves the 4-entry queue and
// written when it completes; a write-to-read bypass keeps back-to-back
// updates of one colloid at full rate
// reset clears accumulators and colloid valid bits
// a stalled result register holds the back stage; the queue keeps req_ready
// high until it is full
// ----------------------------------------------------------------------------
module stress_divergence_face_accumulator_top #(
   parameter int MAX_COLLOIDS = 64,
   parameter int ACC_WIDTH    = 48
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_type,
   input  logic [2:0]                         req_face_dir,
   input  logic [1:0]                         req_neighbour_kind,
   input  logic [sdfa_pkg::ID_W-1:0]          req_colloid_id,
   input  logic signed [sdfa_pkg::IN_W-1:0]   req_centre_c0,
   input  logic signed [sdfa_pkg::IN_W-1:0]   req_centre_c1,
   input  logic signed [sdfa_pkg::IN_W-1:0]   req_centre_c2,
   input  logic signed [sdfa_pkg::IN_W-1:0]   req_neigh_c0,
   input  logic signed [sdfa_pkg::IN_W-1:0]   req_neigh_c1,
   input  logic signed [sdfa_pkg::IN_W-1:0]   req_neigh_c2,
   input  logic                               req_last_face,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_result_kind,
   output logic signed [ACC_WIDTH-1:0]        rsp_vec_x,
   output logic signed [ACC_WIDTH-1:0]        rsp_vec_y,
   output logic signed [ACC_WIDTH-1:0]        rsp_vec_z
);

   logic               q_full;
   logic               q_push;
   logic               q_valid;
   logic               q_pop;
   sdfa_pkg::item_type q_wr_item;
   sdfa_pkg::item_type q_rd_item;

   sdfa_front #(
      .MAX_COLLOIDS (MAX_COLLOIDS)
   ) u_front (
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_face_dir       (req_face_dir),
      .req_neighbour_kind (req_neighbour_kind),
      .req_colloid_id     (req_colloid_id),
      .req_centre_c0      (req_centre_c0),
      .req_centre_c1      (req_centre_c1),
      .req_centre_c2      (req_centre_c2),
      .req_neigh_c0       (req_neigh_c0),
      .req_neigh_c1       (req_neigh_c1),
      .req_neigh_c2       (req_neigh_c2),
      .req_last_face      (req_last_face),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_item             (q_wr_item)
   );

   sdfa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_item  (q_wr_item),
      .full     (q_full),
      .rd_valid (q_valid),
      .rd_item  (q_rd_item),
      .rd_en    (q_pop)
   );

   sdfa_back #(
      .MAX_COLLOIDS (MAX_COLLOIDS),
      .ACC_WIDTH    (ACC_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_rd_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_vec_x       (rsp_vec_x),
      .rsp_vec_y       (rsp_vec_y),
      .rsp_vec_z       (rsp_vec_z)
   );

`ifndef ASSERT_OFF
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_type == sdfa_pkg::REQ_FACE || req_type == sdfa_pkg::REQ_RD_COLLOID ||
       req_type == sdfa_pkg::REQ_RD_WALL) |=> q_valid)
      else $error("accepted beat did not reach the queue");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("back stage popped an empty queue");

   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && !q_valid)
      else $error("result or queue not empty after reset");
`endif

endmodule
